// File: src/detection_cluster_table_assert.svh
// assertion macros for the detection cluster table
`ifndef DETECTION_CLUSTER_TABLE_ASSERT_SVH
`define DETECTION_CLUSTER_TABLE_ASSERT_SVH
`define DCT_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define DCT_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: src/dct_pkg.sv
// shared types and constants for the detection cluster table
package dct_pkg;
  localparam int MaxEntries = 16;
  localparam int FW = 18;
  localparam int DW = 40;
  localparam logic [39:0] ThrReset = 40'd1638400;
  localparam logic [15:0] MinRadReset = 16'd2;
  localparam logic [0:0] CfgThr = 1'b0;
  localparam logic [0:0] CfgMinRad = 1'b1;
  localparam logic [2:0] StMerged = 3'd0;
  localparam logic [2:0] StMatched = 3'd1;
  localparam logic [2:0] StInserted = 3'd2;
  localparam logic [2:0] StDropped = 3'd3;
  localparam logic [2:0] StEntry = 3'd4;
  localparam logic [2:0] StEmpty = 3'd5;

  typedef struct packed {
    logic              op;
    logic signed [17:0] px, py, pz, sx, sy, sz;
    logic [7:0]        ty;
  } item_t;

  function automatic logic signed [17:0] sat18(input logic signed [20:0] v);
    if (v > 21'sd131071) return 18'sd131071;
    if (v < -21'sd131072) return -18'sd131072;
    return v[17:0];
  endfunction

  function automatic logic [18:0] mag18(input logic signed [17:0] v);
    logic signed [18:0] e;
    e = 19'(v);
    return (v < 0) ? 19'(-e) : 19'(e);
  endfunction
endpackage

// File: src/dct_front.sv
// input capture and item queue
module dct_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dct_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output dct_pkg::item_t head
);
  import dct_pkg::*;
  item_t       q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_item;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: src/dct_back.sv
// table walk, merge and dump engine
module dct_back #(
  parameter int MAX_ENTRIES = dct_pkg::MaxEntries
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              empty,
  input  dct_pkg::item_t    head,
  output logic              pop,
  input  logic [39:0]       thr,
  input  logic [15:0]       min_rad,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [5:0]        out_entry_index,
  output logic signed [17:0] out_pos_x, out_pos_y, out_pos_z,
  output logic signed [17:0] out_size_x, out_size_y, out_size_z,
  output logic [7:0]        out_type,
  output logic              out_last
);
  import dct_pkg::*;
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_RD = 7'b0000010, S_SQ = 7'b0000100,
    S_CMP = 7'b0001000, S_MRG = 7'b0010000, S_WR = 7'b0100000,
    S_OUT = 7'b1000000
  } state_t;

  logic signed [17:0] m_px [MAX_ENTRIES];
  logic signed [17:0] m_py [MAX_ENTRIES];
  logic signed [17:0] m_pz [MAX_ENTRIES];
  logic signed [17:0] m_sx [MAX_ENTRIES];
  logic signed [17:0] m_sy [MAX_ENTRIES];
  logic signed [17:0] m_sz [MAX_ENTRIES];
  logic [7:0]         m_ty [MAX_ENTRIES];

  state_t      st_r;
  item_t       it_r;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] out_idx_r;
  logic signed [17:0] ex_r, ey_r, ez_r, esx_r, esy_r, esz_r;
  logic [7:0]  ety_r;
  logic [37:0] qx_r, qy_r, qz_r;
  logic [2:0]  status_r;
  logic        valid_r, last_r, zero_r;
  logic signed [17:0] npx_r, npy_r, npz_r, nsx_r, nsy_r, nsz_r;

  logic signed [18:0] dx, dy, dz;
  logic [39:0] d2;
  logic [18:0] xy, txy;
  logic signed [19:0] r, tr;
  logic signed [20:0] xmax, xmin, ymax, ymin, xs, ys;
  logic signed [17:0] zs;
  logic signed [17:0] ins_sz;
  logic        is_last;

  always_comb begin
    dx = 19'(ex_r) - 19'(it_r.px);
    dy = 19'(ey_r) - 19'(it_r.py);
    dz = 19'(ez_r) - 19'(it_r.pz);
    d2 = 40'(qx_r) + 40'(qy_r) + 40'(qz_r);
    xy = (mag18(it_r.sx) > mag18(it_r.sy)) ? mag18(it_r.sx) : mag18(it_r.sy);
    txy = (mag18(esx_r) > mag18(esy_r)) ? mag18(esx_r) : mag18(esy_r);
    r  = 20'(xy >> 1);
    tr = 20'(txy >> 1);
    xmax = (21'(it_r.px) + 21'(r) > 21'(ex_r) + 21'(tr)) ?
           21'(it_r.px) + 21'(r) : 21'(ex_r) + 21'(tr);
    ymax = (21'(it_r.py) + 21'(r) > 21'(ey_r) + 21'(tr)) ?
           21'(it_r.py) + 21'(r) : 21'(ey_r) + 21'(tr);
    xmin = (21'(it_r.px) - 21'(r) < 21'(ex_r) - 21'(tr)) ?
           21'(it_r.px) - 21'(r) : 21'(ex_r) - 21'(tr);
    ymin = (21'(it_r.py) - 21'(r) < 21'(ey_r) - 21'(tr)) ?
           21'(it_r.py) - 21'(r) : 21'(ey_r) - 21'(tr);
    xs = xmax - xmin;
    ys = ymax - ymin;
    zs = (it_r.sz > esz_r) ? it_r.sz : esz_r;
    ins_sz = sat18(21'(xy));
    is_last = (CW'(idx_r) + CW'(1) == cnt_r);
  end

  assign pop  = (st_r == S_IDLE) && !empty;

  always_ff @(posedge clk) begin
    qx_r <= 38'(dx * dx);
    qy_r <= 38'(dy * dy);
    qz_r <= 38'(dz * dz);
    if (st_r == S_RD) begin
      ex_r <= m_px[idx_r]; ey_r <= m_py[idx_r]; ez_r <= m_pz[idx_r];
      esx_r <= m_sx[idx_r]; esy_r <= m_sy[idx_r]; esz_r <= m_sz[idx_r];
      ety_r <= m_ty[idx_r];
    end
    if (st_r == S_MRG) begin
      if (status_r == StInserted) begin
        npx_r <= it_r.px; npy_r <= it_r.py; npz_r <= it_r.pz;
        nsx_r <= ins_sz; nsy_r <= ins_sz; nsz_r <= it_r.sz;
      end else begin
        npx_r <= sat18(xmin + (xs >>> 1));
        npy_r <= sat18(ymin + (ys >>> 1));
        npz_r <= zs >>> 1;
        nsx_r <= sat18(xs);
        nsy_r <= sat18(ys);
        nsz_r <= zs;
      end
    end
    if (st_r == S_WR) begin
      m_px[idx_r] <= npx_r; m_py[idx_r] <= npy_r; m_pz[idx_r] <= npz_r;
      m_sx[idx_r] <= nsx_r; m_sy[idx_r] <= nsy_r; m_sz[idx_r] <= nsz_r;
      ex_r <= npx_r; ey_r <= npy_r; ez_r <= npz_r;
      esx_r <= nsx_r; esy_r <= nsy_r; esz_r <= nsz_r;
      if (status_r == StInserted) m_ty[idx_r] <= it_r.ty;
      if (status_r == StInserted) ety_r <= it_r.ty;
    end
    if (pop) it_r <= head;
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; idx_r <= '0; valid_r <= 1'b0;
      status_r <= StEmpty; last_r <= 1'b0; zero_r <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (pop) begin
          idx_r <= '0;
          if (cnt_r == '0) begin
            zero_r <= 1'b1; last_r <= 1'b1;
            status_r <= head.op ? StEmpty : StInserted;
            st_r <= head.op ? S_OUT : S_MRG;
          end else begin
            zero_r <= 1'b0;
            st_r <= S_RD;
          end
        end
        S_RD: st_r <= it_r.op ? S_OUT : S_SQ;
        S_SQ: st_r <= S_CMP;
        S_CMP: begin
          if (d2 < thr) begin
            if (r > 20'(min_rad)) begin
              status_r <= StMerged; st_r <= S_MRG;
            end else begin
              status_r <= StMatched; st_r <= S_OUT;
            end
            zero_r <= 1'b0; last_r <= 1'b1;
          end else if (!is_last) begin
            idx_r <= idx_r + IW'(1); st_r <= S_RD;
          end else if (cnt_r == CW'(MAX_ENTRIES)) begin
            status_r <= StDropped; zero_r <= 1'b1; last_r <= 1'b1; st_r <= S_OUT;
          end else begin
            status_r <= StInserted; last_r <= 1'b1;
            idx_r <= IW'(cnt_r); st_r <= S_MRG;
          end
        end
        S_MRG: begin
          st_r <= S_WR;
        end
        S_WR: begin
          zero_r <= 1'b0;
          if (status_r == StInserted) cnt_r <= cnt_r + CW'(1);
          st_r <= S_OUT;
        end
        S_OUT: begin
          valid_r <= 1'b1;
          out_idx_r <= idx_r;
          if (it_r.op && !zero_r) begin
            status_r <= StEntry; last_r <= is_last;
          end
          if (it_r.op && !zero_r && !is_last) begin
            idx_r <= idx_r + IW'(1); st_r <= S_RD;
          end else st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = valid_r;
  assign out_status      = it_r.op && !zero_r ? StEntry : status_r;
  assign out_last        = it_r.op && !zero_r ? last_r : 1'b1;
  assign out_entry_index = zero_r ? 6'd0 : 6'(out_idx_r);
  assign out_pos_x  = zero_r ? '0 : ex_r;
  assign out_pos_y  = zero_r ? '0 : ey_r;
  assign out_pos_z  = zero_r ? '0 : ez_r;
  assign out_size_x = zero_r ? '0 : esx_r;
  assign out_size_y = zero_r ? '0 : esy_r;
  assign out_size_z = zero_r ? '0 : esz_r;
  assign out_type   = zero_r ? '0 : ety_r;
endmodule

// File: src/detection_cluster_table.sv
// top level of the detection cluster table
// usage:
//   cfg_we/cfg_index/cfg_wdata write the threshold (0) or min radius (1)
//   an item is taken when start is high and busy is low
//   a two-deep queue sits in front of the table engine
//   each result shows for one cycle with out_valid; out_last marks the end
//   a detection gives one result, a dump gives one per entry, or one empty result if the table is empty
// processing:
//   detection: the item waits in the queue, then each entry is read, squared and compared,
//   then the new entry is merged, written and emitted; a dump reads and emits each entry
//   the rate is set by the one-entry-at-a-time walk over the slot memory
// reset:
//   the table is empty, threshold 25 m^2, min radius 2
// the receiver cannot stall, so results are never held back
module detection_cluster_table #(
  parameter int MAX_ENTRIES = dct_pkg::MaxEntries
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_operation,
  input  logic signed [17:0] in_pos_x, in_pos_y, in_pos_z,
  input  logic signed [17:0] in_size_x, in_size_y, in_size_z,
  input  logic [7:0]        in_obj_type,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [39:0]       cfg_wdata,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [5:0]        out_entry_index,
  output logic signed [17:0] out_pos_x, out_pos_y, out_pos_z,
  output logic signed [17:0] out_size_x, out_size_y, out_size_z,
  output logic [7:0]        out_type,
  output logic              out_last
);
  import dct_pkg::*;
  logic [39:0] thr_r;
  logic [15:0] minr_r;
  item_t in_item, head;
  logic full, empty, pop, push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ThrReset; minr_r <= MinRadReset;
    end else if (cfg_we) begin
      if (cfg_index == CfgThr) thr_r <= cfg_wdata;
      if (cfg_index == CfgMinRad) minr_r <= cfg_wdata[15:0];
    end
  end

  assign in_item = '{op: in_operation, px: in_pos_x, py: in_pos_y, pz: in_pos_z,
                     sx: in_size_x, sy: in_size_y, sz: in_size_z, ty: in_obj_type};
  assign busy = full;
  assign push = start && !full;

  dct_front u_front (.clk, .rst_n, .push, .push_item(in_item), .full,
                     .pop, .empty, .head);
  dct_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk, .rst_n, .empty, .head, .pop, .thr(thr_r),
    .min_rad(minr_r), .out_valid, .out_status, .out_entry_index,
    .out_pos_x, .out_pos_y, .out_pos_z, .out_size_x, .out_size_y, .out_size_z,
    .out_type, .out_last);
endmodule

// File: src/dct_checker.sv
// port-level checker bound to the top level
module dct_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic [2:0] out_status,
  input logic [5:0] out_entry_index,
  input logic       out_last
);
  import dct_pkg::*;
  `include "detection_cluster_table_assert.svh"
  `DCT_ASSERT_IMPL(a_status_range, clk, rst_n, out_valid, out_status <= StEmpty)
  `DCT_ASSERT_IMPL(a_empty_last, clk, rst_n, out_valid && out_status == StEmpty, out_last)
  `DCT_ASSERT_IMPL(a_drop_idx, clk, rst_n, out_valid && out_status == StDropped, out_entry_index == 6'd0)
endmodule

bind detection_cluster_table dct_checker u_chk (.clk, .rst_n, .out_valid,
  .out_status, .out_entry_index, .out_last);

// File: tb/sv/detection_cluster_table_check.sv
// checker for the detection cluster table: predicts results from accepted items and compares
module detection_cluster_table_check
  import dct_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_operation,
  input  logic signed [17:0] in_pos_x, in_pos_y, in_pos_z,
  input  logic signed [17:0] in_size_x, in_size_y, in_size_z,
  input  logic [7:0]         in_obj_type,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [39:0]        cfg_wdata,
  input  logic               out_valid,
  input  logic [2:0]         out_status,
  input  logic [5:0]         out_entry_index,
  input  logic signed [17:0] out_pos_x, out_pos_y, out_pos_z,
  input  logic signed [17:0] out_size_x, out_size_y, out_size_z,
  input  logic [7:0]         out_type,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count,
  output int                 merge_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]         status;
    logic [5:0]         index;
    logic signed [17:0] px, py, pz, sx, sy, sz;
    logic [7:0]         ty;
    logic               last;
  } table_result_t;

  table_result_t expected_results[$];

  logic [39:0] thr;
  logic [15:0] min_rad;
  int          n_entries;
  longint      tab_px[MaxEntries], tab_py[MaxEntries], tab_pz[MaxEntries];
  longint      tab_sx[MaxEntries], tab_sy[MaxEntries], tab_sz[MaxEntries];
  logic [7:0]  tab_ty[MaxEntries];

  function automatic longint clamp18(input longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint lmax(input longint a, input longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint lmin(input longint a, input longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic table_result_t slot_result(input logic [2:0] st, input int i,
                                                input logic lst);
    table_result_t r;
    r.status = st;
    r.index  = 6'(i);
    r.px = 18'(tab_px[i]);
    r.py = 18'(tab_py[i]);
    r.pz = 18'(tab_pz[i]);
    r.sx = 18'(tab_sx[i]);
    r.sy = 18'(tab_sy[i]);
    r.sz = 18'(tab_sz[i]);
    r.ty = tab_ty[i];
    r.last = lst;
    return r;
  endfunction

  function automatic table_result_t blank_result(input logic [2:0] st);
    table_result_t r;
    r = '{status: st, index: '0, px: '0, py: '0, pz: '0, sx: '0, sy: '0, sz: '0,
          ty: '0, last: 1'b1};
    return r;
  endfunction

  task automatic add_expected(input table_result_t r);
    expected_results = {expected_results, r};
  endtask

  task automatic predict_table_item();
    longint px, py, pz, sz, xy, r, tr, dx, dy, dz, xmax, ymax, xmin, ymin, xs, ys, zs;
    logic [63:0] d2;
    int hit;
    hit = -1;
    if (in_operation) begin
      if (n_entries == 0) add_expected(blank_result(StEmpty));
      for (int i = 0; i < n_entries; i++)
        add_expected(slot_result(StEntry, i, i + 1 == n_entries));
      return;
    end
    px = in_pos_x;
    py = in_pos_y;
    pz = in_pos_z;
    sz = in_size_z;
    xy = lmax(mag(longint'(in_size_x)), mag(longint'(in_size_y)));
    r  = xy >>> 1;
    for (int i = 0; i < n_entries && hit < 0; i++) begin
      dx = tab_px[i] - px;
      dy = tab_py[i] - py;
      dz = tab_pz[i] - pz;
      d2 = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
      if (d2 < {24'd0, thr}) hit = i;
    end
    if (hit >= 0) begin
      if (r > longint'(min_rad)) begin
        tr   = lmax(mag(tab_sx[hit]), mag(tab_sy[hit])) >>> 1;
        xmax = lmax(px + r, tab_px[hit] + tr);
        ymax = lmax(py + r, tab_py[hit] + tr);
        xmin = lmin(px - r, tab_px[hit] - tr);
        ymin = lmin(py - r, tab_py[hit] - tr);
        xs   = xmax - xmin;
        ys   = ymax - ymin;
        zs   = lmax(sz, tab_sz[hit]);
        tab_px[hit] = clamp18(xmin + (xs >>> 1));
        tab_py[hit] = clamp18(ymin + (ys >>> 1));
        tab_pz[hit] = clamp18(zs >>> 1);
        tab_sx[hit] = clamp18(xs);
        tab_sy[hit] = clamp18(ys);
        tab_sz[hit] = clamp18(zs);
        merge_count++;
        add_expected(slot_result(StMerged, hit, 1'b1));
      end else begin
        add_expected(slot_result(StMatched, hit, 1'b1));
      end
    end else if (n_entries >= MaxEntries) begin
      add_expected(blank_result(StDropped));
    end else begin
      tab_px[n_entries] = px;
      tab_py[n_entries] = py;
      tab_pz[n_entries] = pz;
      tab_sx[n_entries] = clamp18(xy);
      tab_sy[n_entries] = clamp18(xy);
      tab_sz[n_entries] = sz;
      tab_ty[n_entries] = in_obj_type;
      add_expected(slot_result(StInserted, n_entries, 1'b1));
      n_entries++;
    end
  endtask

  task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic compare_result();
    table_result_t e;
    result_count++;
    if (expected_results.size() == 0) begin
      report("unexpected result, status", 40'(out_status), '0);
      return;
    end
    e = expected_results.pop_front();
    if (out_status !== e.status) report("status", 40'(out_status), 40'(e.status));
    if (out_entry_index !== e.index) report("entry_index", 40'(out_entry_index), 40'(e.index));
    if (out_pos_x !== e.px) report("pos_x", 40'(out_pos_x), 40'(e.px));
    if (out_pos_y !== e.py) report("pos_y", 40'(out_pos_y), 40'(e.py));
    if (out_pos_z !== e.pz) report("pos_z", 40'(out_pos_z), 40'(e.pz));
    if (out_size_x !== e.sx) report("size_x", 40'(out_size_x), 40'(e.sx));
    if (out_size_y !== e.sy) report("size_y", 40'(out_size_y), 40'(e.sy));
    if (out_size_z !== e.sz) report("size_z", 40'(out_size_z), 40'(e.sz));
    if (out_type !== e.ty) report("type", 40'(out_type), 40'(e.ty));
    if (out_last !== e.last) report("last", 40'(out_last), 40'(e.last));
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    result_count = 0;
    merge_count = 0;
    n_entries = 0;
    thr = ThrReset;
    min_rad = MinRadReset;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      n_entries = 0;
      thr = ThrReset;
      min_rad = MinRadReset;
    end else begin
      if (out_valid === 1'b1) compare_result();
      if (start && !busy) predict_table_item();
      if (cfg_we) begin
        if (cfg_index == CfgThr) thr = cfg_wdata;
        else min_rad = cfg_wdata[15:0];
      end
    end
    pending_count = expected_results.size();
  end
endmodule

// File: tb/sv/detection_cluster_table_test.sv
// testbench top for the detection cluster table: stimulus, configuration phases and verdict
module detection_cluster_table_test;
  import dct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OpDetect = 1'b0;
  localparam logic OpDump = 1'b1;
  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 150;

  logic               clk, rst_n, start, busy;
  logic               in_operation;
  logic signed [17:0] in_pos_x, in_pos_y, in_pos_z, in_size_x, in_size_y, in_size_z;
  logic [7:0]         in_obj_type;
  logic               cfg_we, cfg_index;
  logic [39:0]        cfg_wdata;
  logic               out_valid, out_last;
  logic [2:0]         out_status;
  logic [5:0]         out_entry_index;
  logic signed [17:0] out_pos_x, out_pos_y, out_pos_z, out_size_x, out_size_y, out_size_z;
  logic [7:0]         out_type;
  int                 fail_count, pending_count, result_count, merge_count;
  int                 cycles = 0;
  int                 items_sent, burst_left;
  longint             centers[4];

  detection_cluster_table dut (.*);

  detection_cluster_table_check checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic op, input longint px, input longint py,
                           input longint pz, input longint sx, input longint sy,
                           input longint sz, input logic [7:0] ty);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    start <= 1'b1;
    in_operation <= op;
    in_pos_x <= 18'(px);
    in_pos_y <= 18'(py);
    in_pos_z <= 18'(pz);
    in_size_x <= 18'(sx);
    in_size_y <= 18'(sy);
    in_size_z <= 18'(sz);
    in_obj_type <= ty;
    do @(posedge clk); while (busy);
    items_sent++;
    if (burst_left == 0) start <= 1'b0;
  endtask

  task automatic wait_drained();
    if (burst_left != 0) start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_count != 0 || busy) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [39:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic longint rnd_field(input int spread);
    if ($urandom_range(0, 7) == 0) return longint'($signed(18'($urandom)));
    return longint'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  task automatic random_item();
    longint c;
    if ($urandom_range(0, 9) == 0) begin
      send_item(OpDump, rnd_field(1000), rnd_field(1000), rnd_field(1000),
                rnd_field(1000), rnd_field(1000), rnd_field(1000), 8'($urandom));
    end else if ($urandom_range(0, 4) == 0) begin
      send_item(OpDetect, longint'($signed(18'($urandom))), longint'($signed(18'($urandom))),
                longint'($signed(18'($urandom))), longint'($signed(18'($urandom))),
                longint'($signed(18'($urandom))), longint'($signed(18'($urandom))),
                8'($urandom));
    end else begin
      c = centers[$urandom_range(0, 3)];
      send_item(OpDetect, c + rnd_field(300), c - rnd_field(300), rnd_field(300),
                rnd_field(2000), rnd_field(2000), rnd_field(2000), 8'($urandom));
    end
  endtask

  initial begin
    items_sent = 0;
    burst_left = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OpDetect;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_size_x = '0;
    in_size_y = '0;
    in_size_z = '0;
    in_obj_type = '0;
    cfg_we = 1'b0;
    cfg_index = CfgThr;
    cfg_wdata = '0;
    centers = '{0, 5000, -30000, 120000};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty dump, extreme inserts, merges with saturation, small matches
    send_item(OpDump, 0, 0, 0, 0, 0, 0, 8'h00);
    send_item(OpDetect, 0, 0, 0, -131072, 5, -131072, 8'hff);
    send_item(OpDetect, 131071, 131071, 131071, 131071, 131071, 131071, 8'h00);
    send_item(OpDetect, -131072, -131072, -131072, 3, -131072, 131071, 8'h5a);
    send_item(OpDetect, 131000, 131050, 131071, 131071, -131072, -131072, 8'ha5);
    send_item(OpDetect, -131000, -131000, -131072, -131072, 131071, 100, 8'h11);
    send_item(OpDetect, 10, -10, 20, 5, 4, 7, 8'h22);
    send_item(OpDetect, 12, -8, 18, 6, 3, 9, 8'h33);
    send_item(OpDetect, 30000, 0, 0, 4, 5, 1, 8'h44);
    send_item(OpDetect, 30001, 1, 0, 3, 2, 1, 8'h55);
    send_item(OpDump, 0, 0, 0, 0, 0, 0, 8'h00);
    for (int i = 0; i < 14; i++)
      send_item(OpDetect, -60000 + i * 9000, 70000 - i * 7000, i * 3000, 2000 + i, -1500, 900,
                8'(i));
    send_item(OpDump, 0, 0, 0, 0, 0, 0, 8'h00);
    wait_drained();

    write_reg(CfgThr, 40'd400000);
    write_reg(CfgMinRad, 40'd0);
    repeat (40) random_item();
    write_reg(CfgThr, {40{1'b1}});
    write_reg(CfgMinRad, 40'hffff);
    repeat (20) random_item();
    write_reg(CfgMinRad, 40'd0);
    repeat (15) random_item();
    write_reg(CfgThr, 40'd0);
    write_reg(CfgMinRad, 40'(MinRadReset));
    repeat (25) random_item();

    wait_drained();
    $display("sent %0d items over five register settings, %0d results checked, %0d merges",
             items_sent, result_count, merge_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending_count);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
